FILE: design/bkhs_pkg.sv
// ----------------------------------------------------------------------------
// bkhs_pkg: shared types and constants of the bucketed key set
// Sizes of the store, operation codes and the structs that pass between the
// sequencer and the entry store.
// ----------------------------------------------------------------------------
package bkhs_pkg;

    localparam int KEY_BYTES    = 8;
    localparam int BUCKETS      = 256;
    localparam int BUCKET_DEPTH = 8;

    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 64;
    localparam int BUCKET_IN_W = 8;
    localparam int TOT_W       = 12;

    localparam int SLOTS  = BUCKETS * BUCKET_DEPTH;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int DEP_W  = $clog2(BUCKET_DEPTH);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PURGE  = 2'd2;

    typedef struct packed {
        logic             mark;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [KEY_W-1:0]       key;
        logic [BUCKET_IN_W-1:0] bucket;
        logic                   mark;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic              error_code;
        logic [TOT_W-1:0]  total_count;
    } result_t;

    typedef struct packed {
        logic              ent_rd_en;
        logic [SLOT_W-1:0] ent_rd_addr;
        logic              ent_wr_en;
        logic [SLOT_W-1:0] ent_wr_addr;
        entry_t            ent_wr_data;
        logic [BKT_W-1:0]  fill_rd_addr;
        logic              fill_wr_en;
        logic [BKT_W-1:0]  fill_wr_addr;
        logic [FILL_W-1:0] fill_wr_data;
    } store_req_t;

    typedef struct packed {
        entry_t            ent_rd_data;
        logic [FILL_W-1:0] fill_rd_data;
    } store_rsp_t;

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                    input logic [DEP_W-1:0] idx);
        return {bkt, idx};
    endfunction

endpackage

FILE: design/bkhs_in_if.sv
// ----------------------------------------------------------------------------
// bkhs_in_if: request channel
// Valid/ready channel that carries one operation item into the key set.
// ----------------------------------------------------------------------------
interface bkhs_in_if;
    import bkhs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [KEY_W-1:0]       key;
    logic [BUCKET_IN_W-1:0] bucket;
    logic                   mark;

    modport source (output valid, output func, output key, output bucket, output mark,
                    input ready);
    modport sink   (input valid, input func, input key, input bucket, input mark,
                    output ready);
endinterface

FILE: design/bkhs_out_if.sv
// ----------------------------------------------------------------------------
// bkhs_out_if: result channel
// Valid/ready channel that carries one result item out of the key set.
// ----------------------------------------------------------------------------
interface bkhs_out_if;
    import bkhs_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic             error_code;
    logic [TOT_W-1:0] total_count;

    modport source (output valid, output found, output error_code, output total_count,
                    input ready);
    modport sink   (input valid, input found, input error_code, input total_count,
                    output ready);
endinterface

FILE: design/bkhs_store.sv
// ----------------------------------------------------------------------------
// bkhs_store: entry and fill storage
// Entry memory of key plus hit mark, bucket fill memory and its valid bits.
// All reads are registered; a bucket whose fill was never written reads 0.
// ----------------------------------------------------------------------------
module bkhs_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bkhs_pkg::store_req_t  req,
    output bkhs_pkg::store_rsp_t  rsp
);
    import bkhs_pkg::*;

    entry_t            ent_mem [SLOTS];
    logic [FILL_W-1:0] fill_mem [BUCKETS];
    logic [BUCKETS-1:0] fill_valid_reg;
    entry_t            ent_q_reg;
    logic [FILL_W-1:0] fill_q_reg;
    logic              fill_vq_reg;

    always_ff @(posedge clk)
    begin
        if (req.ent_wr_en)
        begin
            ent_mem[req.ent_wr_addr] <= req.ent_wr_data;
        end
        if (req.ent_rd_en)
        begin
            ent_q_reg <= ent_mem[req.ent_rd_addr];
        end
        if (req.fill_wr_en)
        begin
            fill_mem[req.fill_wr_addr] <= req.fill_wr_data;
        end
        fill_q_reg <= fill_mem[req.fill_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_valid_reg <= '0;
            fill_vq_reg    <= 1'b0;
        end
        else
        begin
            if (req.fill_wr_en)
            begin
                fill_valid_reg[req.fill_wr_addr] <= 1'b1;
            end
            fill_vq_reg <= fill_valid_reg[req.fill_rd_addr];
        end
    end

    assign rsp.ent_rd_data  = ent_q_reg;
    assign rsp.fill_rd_data = fill_vq_reg ? fill_q_reg : '0;

endmodule

FILE: design/bkhs_ctrl.sv
// ----------------------------------------------------------------------------
// bkhs_ctrl: operation sequencer
// Walks bucket entries one at a time, comparing keys for insert and lookup
// and marks for purge, and issues the store reads and writes for each.
// ----------------------------------------------------------------------------
module bkhs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bkhs_pkg::cmd_t        cmd,
    output bkhs_pkg::store_req_t  req,
    input  bkhs_pkg::store_rsp_t  rsp,
    output logic                  done,
    output bkhs_pkg::result_t     res,
    input  logic                  take
);
    import bkhs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_FIN    = 4'd3;
    localparam logic [3:0] S_DONE   = 4'd4;
    localparam logic [3:0] S_P_RQ   = 4'd5;
    localparam logic [3:0] S_P_FILL = 4'd6;
    localparam logic [3:0] S_P_RDI  = 4'd7;
    localparam logic [3:0] S_P_CHKI = 4'd8;
    localparam logic [3:0] S_P_SRCH = 4'd9;
    localparam logic [3:0] S_P_CHKJ = 4'd10;
    localparam logic [3:0] S_P_WB   = 4'd11;

    logic [3:0]        state_reg,  state_next;
    logic [FUNC_W-1:0] func_reg,   func_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    logic [BKT_W-1:0]  bkt_reg,    bkt_next;
    logic              mark_reg,   mark_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [DEP_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              pend_reg,   pend_next;
    logic [DEP_W-1:0]  hit_reg,    hit_next;
    logic              found_reg,  found_next;
    logic              err_reg,    err_next;
    logic [TOT_W-1:0]  total_reg,  total_next;
    logic [FILL_W-1:0] pi_reg,     pi_next;
    logic [FILL_W-1:0] pj_reg,     pj_next;
    logic [BKT_W-1:0]  pbkt_reg,   pbkt_next;
    logic [TOT_W-1:0]  psum_reg,   psum_next;

    logic              match_now;
    logic              issue;
    entry_t            ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        bkt_reg     <= bkt_next;
        mark_reg    <= mark_next;
        fill_reg    <= fill_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        err_reg     <= err_next;
        pi_reg      <= pi_next;
        pj_reg      <= pj_next;
        pbkt_reg    <= pbkt_next;
        psum_reg    <= psum_next;
    end

    always_comb
    begin
        ent          = rsp.ent_rd_data;
        state_next   = state_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        bkt_next     = bkt_reg;
        mark_next    = mark_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        err_next     = err_reg;
        total_next   = total_reg;
        pi_next      = pi_reg;
        pj_next      = pj_reg;
        pbkt_next    = pbkt_reg;
        psum_next    = psum_reg;
        req          = '0;
        req.fill_rd_addr = pbkt_reg;
        done         = 1'b0;
        in_ready     = (state_reg == S_IDLE);
        match_now    = pend_reg && (((ent.key ^ key_reg) & KEY_MASK) == '0);
        issue        = (rd_idx_reg < fill_reg) && !match_now;

        unique case (state_reg)
            S_IDLE:
            begin
                req.fill_rd_addr = cmd.bucket[BKT_W-1:0];
                if (in_valid)
                begin
                    func_next  = cmd.func;
                    key_next   = cmd.key;
                    bkt_next   = cmd.bucket[BKT_W-1:0];
                    mark_next  = cmd.mark;
                    found_next = 1'b0;
                    err_next   = 1'b0;
                    pbkt_next  = '0;
                    psum_next  = '0;
                    unique case (cmd.func) inside
                        FUNC_INSERT, FUNC_LOOKUP: state_next = S_FILL;
                        FUNC_PURGE:               state_next = S_P_RQ;
                        default:                  state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                fill_next   = rsp.fill_rd_data;
                rd_idx_next = '0;
                pend_next   = 1'b0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (match_now)
                begin
                    found_next = 1'b1;
                    hit_next   = cmp_idx_reg;
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    req.ent_rd_en   = issue;
                    req.ent_rd_addr = slot_addr(bkt_reg, rd_idx_reg[DEP_W-1:0]);
                    pend_next       = issue;
                    cmp_idx_next    = rd_idx_reg[DEP_W-1:0];
                    if (issue)
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (func_reg == FUNC_LOOKUP)
                begin
                    if (found_reg)
                    begin
                        req.ent_wr_en   = 1'b1;
                        req.ent_wr_addr = slot_addr(bkt_reg, hit_reg);
                        req.ent_wr_data = '{mark: ent.mark | mark_reg, key: ent.key};
                    end
                end
                else if (!found_reg)
                begin
                    if (fill_reg >= FILL_W'(BUCKET_DEPTH))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        req.ent_wr_en    = 1'b1;
                        req.ent_wr_addr  = slot_addr(bkt_reg, fill_reg[DEP_W-1:0]);
                        req.ent_wr_data  = '{mark: 1'b0, key: key_reg};
                        req.fill_wr_en   = 1'b1;
                        req.fill_wr_addr = bkt_reg;
                        req.fill_wr_data = fill_reg + 1'b1;
                        total_next       = total_reg + 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            S_P_RQ:
            begin
                state_next = S_P_FILL;
            end
            S_P_FILL:
            begin
                fill_next  = rsp.fill_rd_data;
                pi_next    = '0;
                state_next = S_P_RDI;
            end
            S_P_RDI:
            begin
                if (pi_reg < fill_reg)
                begin
                    req.ent_rd_en   = 1'b1;
                    req.ent_rd_addr = slot_addr(pbkt_reg, pi_reg[DEP_W-1:0]);
                    state_next      = S_P_CHKI;
                end
                else
                begin
                    state_next = S_P_WB;
                end
            end
            S_P_CHKI:
            begin
                if (ent.mark != mark_reg)
                begin
                    req.ent_wr_en   = 1'b1;
                    req.ent_wr_addr = slot_addr(pbkt_reg, pi_reg[DEP_W-1:0]);
                    req.ent_wr_data = '{mark: 1'b0, key: ent.key};
                    pi_next         = pi_reg + 1'b1;
                    state_next      = S_P_RDI;
                end
                else
                begin
                    pj_next    = fill_reg - 1'b1;
                    state_next = S_P_SRCH;
                end
            end
            S_P_SRCH:
            begin
                if (pj_reg > pi_reg)
                begin
                    req.ent_rd_en   = 1'b1;
                    req.ent_rd_addr = slot_addr(pbkt_reg, pj_reg[DEP_W-1:0]);
                    state_next      = S_P_CHKJ;
                end
                else
                begin
                    fill_next  = pi_reg;
                    state_next = S_P_WB;
                end
            end
            S_P_CHKJ:
            begin
                if (ent.mark != mark_reg)
                begin
                    req.ent_wr_en   = 1'b1;
                    req.ent_wr_addr = slot_addr(pbkt_reg, pi_reg[DEP_W-1:0]);
                    req.ent_wr_data = '{mark: 1'b0, key: ent.key};
                    fill_next       = pj_reg;
                    pi_next         = pi_reg + 1'b1;
                    state_next      = S_P_RDI;
                end
                else
                begin
                    pj_next    = pj_reg - 1'b1;
                    state_next = S_P_SRCH;
                end
            end
            S_P_WB:
            begin
                req.fill_wr_en   = 1'b1;
                req.fill_wr_addr = pbkt_reg;
                req.fill_wr_data = fill_reg;
                psum_next        = psum_reg + TOT_W'(fill_reg);
                if (pbkt_reg == BKT_W'(BUCKETS - 1))
                begin
                    total_next = psum_reg + TOT_W'(fill_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    pbkt_next  = pbkt_reg + 1'b1;
                    state_next = S_P_RQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.found       = found_reg;
    assign res.error_code  = err_reg;
    assign res.total_count = total_reg;

endmodule

FILE: design/bucketed_key_set_with_hit_marks_unit.sv
// ----------------------------------------------------------------------------
// bucketed_key_set_with_hit_marks_unit: hashed key set with hit marks
// Insert, lookup and purge over fixed-depth buckets, one item at a time.
// Insert and lookup read the bucket fill and then scan its entries in turn;
// an unused code goes straight to the result; purge walks every bucket.
// The next item is accepted once a result has entered the result register;
// a result held there blocks only the following result.
// Reset: clears control, entry count and all bucket fill valid bits at once;
//   no clearing pass. Entry memory contents need no reset.
// ----------------------------------------------------------------------------
module bucketed_key_set_with_hit_marks_unit (
    input  logic        clk,
    input  logic        rst_n,
    bkhs_in_if.sink     request,
    bkhs_out_if.source  result
);
    import bkhs_pkg::*;

    cmd_t       cmd;
    store_req_t st_req;
    store_rsp_t st_rsp;
    logic       done;
    logic       take;
    logic       ready;
    result_t    res;

    logic       out_valid_reg;
    result_t    out_data_reg;

    assign cmd.func   = request.func;
    assign cmd.key    = request.key;
    assign cmd.bucket = request.bucket;
    assign cmd.mark   = request.mark;
    assign request.ready = ready;

    bkhs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (ready),
        .cmd      (cmd),
        .req      (st_req),
        .rsp      (st_rsp),
        .done     (done),
        .res      (res),
        .take     (take)
    );

    bkhs_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rsp   (st_rsp)
    );

    assign take = done && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = out_data_reg.found;
    assign result.error_code  = out_data_reg.error_code;
    assign result.total_count = out_data_reg.total_count;

endmodule

FILE: bench/bucketed_key_set_with_hit_marks_unit_test.sv
// ----------------------------------------------------------------------------
// bucketed_key_set_with_hit_marks_unit_test: self-checking bench of the key set
// Drives insert, lookup, purge and unused-code items through the request
// channel and checks every result against a cycle-free model of the buckets,
// their fill levels and hit marks. A directed opening covers empty, full and
// duplicate buckets and both purge marks. Random traffic follows, with the
// sender and the receiver stalling in turn and then running flat out.
// ----------------------------------------------------------------------------
module bucketed_key_set_with_hit_marks_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bkhs_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RAND_ITEMS  = 1380;
    localparam int POOL_SIZE   = 12;
    localparam int QUIET_LIMIT = 50000;
    localparam int DRAIN_WAIT  = 16;

    class key_set_tracker;
        logic [KEY_W-1:0] stored_keys [SLOTS];
        bit               hit_bits    [SLOTS];
        int unsigned      bucket_len  [BUCKETS];
        int unsigned      key_total;
        result_t          awaited [$];
        int unsigned      failures;

        function new();
            foreach (bucket_len[i])
                bucket_len[i] = 0;
            key_total = 0;
            failures  = 0;
        endfunction

        function int find_slot(int unsigned base, int unsigned fill, logic [KEY_W-1:0] k);
            for (int unsigned i = 0; i < fill; i++)
                if (((stored_keys[base + i] ^ k) & KEY_MASK) == '0)
                    return int'(i);
            return -1;
        endfunction

        // drop entries carrying mark m, refill holes from the tail, clear marks
        function int unsigned compact_bucket(int unsigned base, int unsigned fill, bit m);
            int unsigned i;
            int unsigned j;
            j = fill;
            i = 0;
            while (i < fill)
            begin
                if (hit_bits[base + i] == m)
                begin
                    for (j = j - 1; j > i; j--)
                    begin
                        if (hit_bits[base + j] != m)
                        begin
                            stored_keys[base + i] = stored_keys[base + j];
                            hit_bits[base + i]    = hit_bits[base + j];
                            break;
                        end
                    end
                    fill = j;
                end
                hit_bits[base + i] = 1'b0;
                i++;
            end
            return fill;
        endfunction

        function result_t predict(cmd_t c);
            result_t     r;
            int unsigned b;
            int unsigned base;
            int unsigned fill;
            int unsigned f;
            int          hit;
            r    = '0;
            b    = int'(c.bucket) % BUCKETS;
            base = b * BUCKET_DEPTH;
            fill = (bucket_len[b] > BUCKET_DEPTH) ? BUCKET_DEPTH : bucket_len[b];
            case (c.func)
                FUNC_INSERT:
                begin
                    hit = find_slot(base, fill, c.key);
                    if (hit >= 0)
                        r.found = 1'b1;
                    else if (fill >= BUCKET_DEPTH)
                        r.error_code = 1'b1;
                    else
                    begin
                        stored_keys[base + fill] = c.key;
                        hit_bits[base + fill]    = 1'b0;
                        bucket_len[b]            = fill + 1;
                        key_total++;
                    end
                end
                FUNC_LOOKUP:
                begin
                    hit = find_slot(base, fill, c.key);
                    if (hit >= 0)
                    begin
                        r.found = 1'b1;
                        hit_bits[base + hit] = hit_bits[base + hit] | c.mark;
                    end
                end
                FUNC_PURGE:
                begin
                    key_total = 0;
                    for (int unsigned k = 0; k < BUCKETS; k++)
                    begin
                        f = (bucket_len[k] > BUCKET_DEPTH) ? BUCKET_DEPTH : bucket_len[k];
                        bucket_len[k] = compact_bucket(k * BUCKET_DEPTH, f, c.mark);
                        key_total += bucket_len[k];
                    end
                end
                default:
                begin
                end
            endcase
            r.total_count = key_total[TOT_W-1:0];
            return r;
        endfunction

        function void note_request(cmd_t c);
            awaited.push_back(predict(c));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with none awaited: found %0d error_code %0d total %0d",
                         $time, got.found, got.error_code, got.total_count);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                failures++;
            end
            if (got.error_code !== want.error_code)
            begin
                $display("%0t: error_code expected %0d actual %0d",
                         $time, want.error_code, got.error_code);
                failures++;
            end
            if (got.total_count !== want.total_count)
            begin
                $display("%0t: total_count expected %0d actual %0d",
                         $time, want.total_count, got.total_count);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bkhs_in_if  req_if ();
    bkhs_out_if res_if ();

    bucketed_key_set_with_hit_marks_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    key_set_tracker   tracker;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               sender_idle_pct;
    int               receiver_idle_pct;
    int               quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                             input int b, input bit m);
        cmd_t c;
        c.func   = f;
        c.key    = k;
        c.bucket = b[BUCKET_IN_W-1:0];
        c.mark   = m;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= c.func;
        req_if.key    <= c.key;
        req_if.bucket <= c.bucket;
        req_if.mark   <= c.mark;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        tracker.note_request(c);
    endtask

    task automatic send_random_item();
        int               r;
        int               b;
        logic [KEY_W-1:0] k;
        logic [FUNC_W-1:0] f;
        r = $urandom_range(0, 999);
        if (r < 470)
            f = FUNC_INSERT;
        else if (r < 950)
            f = FUNC_LOOKUP;
        else if (r < 975)
            f = FUNC_UNUSED;
        else
            f = FUNC_PURGE;
        r = $urandom_range(0, 99);
        if (r < 60)
            b = $urandom_range(0, 5);
        else if (r < 70)
            b = $urandom_range(250, 255);
        else
            b = $urandom_range(0, 255);
        if ($urandom_range(0, 99) < 85)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            k = {$urandom, $urandom};
        send_item(f, k, b, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        tracker = new();
        sender_idle_pct   = 16;
        receiver_idle_pct = 85;
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.func   <= FUNC_INSERT;
        req_if.key    <= '0;
        req_if.bucket <= '0;
        req_if.mark   <= 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_LOOKUP, key_pool[0], 0, 1'b1);
        send_item(FUNC_INSERT, key_pool[0], 0, 1'b0);
        send_item(FUNC_INSERT, key_pool[1], 255, 1'b1);
        send_item(FUNC_INSERT, key_pool[1], 0, 1'b0);
        send_item(FUNC_INSERT, key_pool[0], 0, 1'b0);
        send_item(FUNC_LOOKUP, key_pool[0], 0, 1'b1);
        send_item(FUNC_LOOKUP, key_pool[1], 255, 1'b0);
        for (int i = 2; i < 2 + BUCKET_DEPTH; i++)
            send_item(FUNC_INSERT, key_pool[i], 7, i[0]);
        send_item(FUNC_INSERT, key_pool[10], 7, 1'b0);
        send_item(FUNC_INSERT, key_pool[2], 7, 1'b0);
        send_item(FUNC_LOOKUP, key_pool[3], 7, 1'b1);
        send_item(FUNC_LOOKUP, key_pool[5], 7, 1'b1);
        send_item(FUNC_UNUSED, key_pool[3], 7, 1'b1);
        send_item(FUNC_PURGE, key_pool[1], 255, 1'b1);
        send_item(FUNC_LOOKUP, key_pool[0], 0, 1'b0);
        send_item(FUNC_PURGE, key_pool[0], 0, 1'b0);
        send_item(FUNC_INSERT, key_pool[4], 7, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                sender_idle_pct   = 85;
                receiver_idle_pct = 16;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            send_random_item();
        end
        req_if.valid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        result_t got;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                got.found       = res_if.found;
                got.error_code  = res_if.error_code;
                got.total_count = res_if.total_count;
                tracker.check_result(got);
            end
            res_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
design/bkhs_pkg.sv
design/bkhs_in_if.sv
design/bkhs_out_if.sv
design/bkhs_store.sv
design/bkhs_ctrl.sv
design/bucketed_key_set_with_hit_marks_unit.sv
bench/bucketed_key_set_with_hit_marks_unit_test.sv
